@@ design/esm_pkg.sv @@
package esm_pkg;

    localparam int AVERAGE_COUNT = 2;
    localparam int DIV_W         = 42;
    localparam int STEP_W        = 6;
    localparam int ADDR_W        = 4;

    localparam logic [3:0]        AVG_TRIGGER   = 4'(AVERAGE_COUNT);
    localparam logic [31:0]       AVG_DIVISOR   = 32'(AVERAGE_COUNT);
    localparam logic [31:0]       FREQ_NUM_Q8   = 32'd256000000;
    localparam logic [STEP_W-1:0] STEPS_SHORT   = STEP_W'(32);
    localparam logic [STEP_W-1:0] STEPS_LONG    = STEP_W'(DIV_W);

    localparam logic [15:0] PULSES_RESET  = 16'd11;
    localparam logic [15:0] GEAR_RESET    = 16'd2458;
    localparam logic [31:0] TIMEOUT_RESET = 32'd200000;

    localparam logic [1:0] REG_PULSES  = 2'd0;
    localparam logic [1:0] REG_GEAR    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_REV  = 2'b11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_AVG_DIV,
        ST_UPDATE,
        ST_FREQ_DIV,
        ST_SPEED_PREP,
        ST_SPEED_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] pulses;
        logic [15:0] gear;
        logic [31:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [31:0]       divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ design/encoder_speed_meter_core.sv @@
// Period-based speed meter for a quadrature encoder. Each request is either a channel-A rising
// edge or a speed update, and each gives exactly one result. An edge request passes through the
// edge stage to the output stage, and when it completes an average it first waits while the
// average is formed by the bit-serial divider in 32 steps. An update goes straight to the
// output stage when the last edge has timed out or no averaged period exists yet. Otherwise the
// same divider, one quotient bit per cycle, first forms the frequency, kept to 28 bits. When
// that frequency is zero the update then goes to the output stage. When it is not zero the
// divider then forms the 42-bit speed quotient. The result appears in the same cycle as the
// block can take its next request. A new request is taken as soon as the previous one has left
// the working stages, even while its result still waits in the output register. An earlier
// result, still stalled in that register, holds the request in the output stage.
module encoder_speed_meter_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       operation,
    input  logic [31:0]                time_us,
    input  logic                       channel_b_level,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [31:0]         pulse_count,
    output logic signed [1:0]          direction,
    output logic [31:0]                period_us,
    output logic [27:0]                frequency_hz_q8,
    output logic signed [31:0]         speed_rpm_q8,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [esm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import esm_pkg::*;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t      state_reg,     state_next;
    logic [31:0] time_reg,      time_next;
    logic        b_reg,         b_next;
    logic [31:0] last_reg,      last_next;
    logic [31:0] sum_reg,       sum_next;
    logic [3:0]  collected_reg, collected_next;
    logic [31:0] avg_reg,       avg_next;
    logic [1:0]  edge_dir_reg,  edge_dir_next;
    logic [31:0] count_reg,     count_next;
    logic [27:0] freq_reg,      freq_next;
    logic [31:0] speed_reg,     speed_next;
    logic [1:0]  dir_out_reg,   dir_out_next;
    logic [31:0] denom_reg,     denom_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_count_reg;
    logic [1:0]  out_dir_reg;
    logic [31:0] out_period_reg;
    logic [27:0] out_freq_reg;
    logic [31:0] out_speed_reg;

    logic             out_load;
    logic [31:0]      elapsed;
    logic [31:0]      sum_total;
    logic [3:0]       collected_inc;
    logic [DIV_W-1:0] speed_num;

    function automatic logic [31:0] saturate(input logic [DIV_W-1:0] mag, input logic [1:0] dir);
        logic [31:0] res;
        res = 32'd0;
        if (dir == DIR_FWD)
        begin
            res = (|mag[DIV_W-1:31]) ? 32'h7FFF_FFFF : mag[31:0];
        end
        else if (dir == DIR_REV)
        begin
            res = ((|mag[DIV_W-1:32]) || (mag[31] && (|mag[30:0])))
                ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end
        return res;
    endfunction

    esm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        collected_next = collected_reg;
        avg_next       = avg_reg;
        edge_dir_next  = edge_dir_reg;
        count_next     = count_reg;
        freq_next      = freq_reg;
        speed_next     = speed_reg;
        dir_out_next   = dir_out_reg;
        denom_next     = denom_reg;
        div_req        = '0;
        out_load       = 1'b0;

        elapsed       = time_reg - last_reg;
        sum_total     = sum_reg + elapsed;
        collected_inc = collected_reg + 4'd1;
        // Frequency times 60 * 256 is formed as (f << 14) - (f << 10).
        speed_num     = {freq_reg, 14'd0} - {4'd0, freq_reg, 10'd0};

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    time_next  = time_us;
                    b_next     = channel_b_level;
                    state_next = operation ? ST_UPDATE : ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                last_next = time_reg;
                if (b_reg)
                begin
                    count_next    = count_reg - 32'd1;
                    edge_dir_next = DIR_REV;
                    dir_out_next  = DIR_REV;
                end
                else
                begin
                    count_next    = count_reg + 32'd1;
                    edge_dir_next = DIR_FWD;
                    dir_out_next  = DIR_FWD;
                end
                if (collected_inc >= AVG_TRIGGER)
                begin
                    collected_next   = 4'd0;
                    sum_next         = 32'd0;
                    div_req.start    = 1'b1;
                    div_req.dividend = {sum_total, {(DIV_W-32){1'b0}}};
                    div_req.divisor  = AVG_DIVISOR;
                    div_req.steps    = STEPS_SHORT;
                    state_next       = ST_AVG_DIV;
                end
                else
                begin
                    collected_next = collected_inc;
                    sum_next       = sum_total;
                    state_next     = ST_EMIT;
                end
            end
            ST_AVG_DIV:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[31:0];
                    state_next = ST_EMIT;
                end
            end
            ST_UPDATE:
            begin
                if ((elapsed <= cfg.timeout) && (avg_reg != 32'd0))
                begin
                    dir_out_next     = edge_dir_reg;
                    div_req.start    = 1'b1;
                    div_req.dividend = {FREQ_NUM_Q8, {(DIV_W-32){1'b0}}};
                    div_req.divisor  = avg_reg;
                    div_req.steps    = STEPS_SHORT;
                    state_next       = ST_FREQ_DIV;
                end
                else
                begin
                    dir_out_next = DIR_NONE;
                    freq_next    = 28'd0;
                    speed_next   = 32'd0;
                    state_next   = ST_EMIT;
                end
            end
            ST_FREQ_DIV:
            begin
                if (div_rsp.done)
                begin
                    freq_next  = div_rsp.quotient[27:0];
                    denom_next = 32'(cfg.pulses) * 32'(cfg.gear);
                    if (div_rsp.quotient[27:0] == 28'd0)
                    begin
                        speed_next = 32'd0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SPEED_PREP;
                    end
                end
            end
            ST_SPEED_PREP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = speed_num;
                div_req.divisor  = denom_reg;
                div_req.steps    = STEPS_LONG;
                state_next       = ST_SPEED_DIV;
            end
            ST_SPEED_DIV:
            begin
                if (div_rsp.done)
                begin
                    speed_next = saturate(div_rsp.quotient, dir_out_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            sum_reg       <= '0;
            collected_reg <= '0;
            avg_reg       <= '0;
            edge_dir_reg  <= DIR_NONE;
            count_reg     <= '0;
            freq_reg      <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            sum_reg       <= sum_next;
            collected_reg <= collected_next;
            avg_reg       <= avg_next;
            edge_dir_reg  <= edge_dir_next;
            count_reg     <= count_next;
            freq_reg      <= freq_next;
            speed_reg     <= speed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        b_reg       <= b_next;
        dir_out_reg <= dir_out_next;
        denom_reg   <= denom_next;
        if (out_load)
        begin
            out_count_reg  <= count_reg;
            out_dir_reg    <= dir_out_reg;
            out_period_reg <= avg_reg;
            out_freq_reg   <= freq_reg;
            out_speed_reg  <= speed_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign pulse_count     = out_count_reg;
    assign direction       = out_dir_reg;
    assign period_us       = out_period_reg;
    assign frequency_hz_q8 = out_freq_reg;
    assign speed_rpm_q8    = out_speed_reg;

    // An accepted edge request always goes to the edge stage, and an update to the update stage.
    a_edge_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !operation |=> state_reg == ST_EDGE)
        else $error("edge request not dispatched to the edge stage");

    a_update_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && operation |=> state_reg == ST_UPDATE)
        else $error("update request not dispatched to the update stage");

    // The divider only finishes while the controller is waiting for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_AVG_DIV || state_reg == ST_FREQ_DIV
                          || state_reg == ST_SPEED_DIV))
        else $error("divider finished outside a division stage");

    // A non-zero speed can only come from a non-zero frequency.
    a_speed_needs_freq: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (speed_rpm_q8 != 32'sd0) |-> frequency_hz_q8 != 28'd0)
        else $error("non-zero speed reported with zero frequency");

endmodule

@@ design/esm_cfg.sv @@
module esm_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [esm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output esm_pkg::cfg_t              cfg
);
    import esm_pkg::*;

    logic [15:0] pulses_reg;
    logic [15:0] gear_reg;
    logic [31:0] timeout_reg;
    logic        write_en;
    logic [1:0]  index;

    assign pready   = 1'b1;
    assign index    = paddr[3:2];
    assign write_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulses_reg  <= PULSES_RESET;
            gear_reg    <= GEAR_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (write_en)
        begin
            case (index)
                REG_PULSES:  pulses_reg  <= pwdata[15:0];
                REG_GEAR:    gear_reg    <= pwdata[15:0];
                REG_TIMEOUT: timeout_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_PULSES:  prdata = {16'd0, pulses_reg};
            REG_GEAR:    prdata = {16'd0, gear_reg};
            REG_TIMEOUT: prdata = timeout_reg;
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.pulses  = pulses_reg;
    assign cfg.gear    = gear_reg;
    assign cfg.timeout = timeout_reg;

endmodule

@@ design/esm_div.sv @@
module esm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  esm_pkg::div_req_t req,
    output esm_pkg::div_rsp_t rsp
);
    import esm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] count_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       divisor_reg;
    logic [32:0]       rem_shift;
    logic [33:0]       diff;
    logic              fits;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[DIV_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, divisor_reg};
        fits      = !diff[33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= req.steps;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - STEP_W'(1);
                if (count_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[31:0] : rem_shift[31:0];
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

@@ tb/sv/tb_encoder_speed_meter_core.sv @@
`timescale 1ns / 1ps

module tb_encoder_speed_meter_core;

    import esm_pkg::*;

    localparam logic        OP_EDGE           = 1'b0;
    localparam logic        OP_UPDATE         = 1'b1;
    localparam logic [1:0]  REG_UNUSED        = 2'd3;
    localparam logic [63:0] RPM_SCALE_Q8      = 64'd60 * 64'd256;
    localparam int          PLAN_ROWS         = 24;
    localparam int          SETTINGS_USED     = 6;
    localparam int          ITEMS_PER_SETTING = 296;
    localparam int          DRAIN_CYCLES      = 120;
    localparam int          CYCLE_LIMIT       = 1000000;

    typedef struct packed {
        logic signed [31:0] count;
        logic [1:0]         dir;
        logic [31:0]        period;
        logic [27:0]        freq;
        logic signed [31:0] speed;
    } reading_t;

    typedef struct packed {
        logic        op;
        logic [31:0] t;
        logic        b;
        logic        known;
        reading_t    want;
    } plan_row_t;

    typedef enum logic [1:0] {
        HOLD_OPEN,
        HOLD_COIN,
        HOLD_LONG,
        HOLD_SPARSE
    } stall_mode_t;

    localparam reading_t NO_READING = '0;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic                operation;
    logic [31:0]         time_us;
    logic                channel_b_level;
    logic                result_valid;
    logic                result_stall;
    logic signed [31:0]  pulse_count;
    logic signed [1:0]   direction;
    logic [31:0]         period_us;
    logic [27:0]         frequency_hz_q8;
    logic signed [31:0]  speed_rpm_q8;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    encoder_speed_meter_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .operation       (operation),
        .time_us         (time_us),
        .channel_b_level (channel_b_level),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .pulse_count     (pulse_count),
        .direction       (direction),
        .period_us       (period_us),
        .frequency_hz_q8 (frequency_hz_q8),
        .speed_rpm_q8    (speed_rpm_q8),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Shadow copy of the meter's registers and state.
    cfg_t               meter_cfg;
    logic [31:0]        last_edge_us;
    logic [31:0]        period_total;
    logic [3:0]         periods_seen;
    logic [31:0]        mean_period;
    logic [1:0]         edge_dir;
    logic signed [31:0] edge_total;
    logic [31:0]        freq_q8;
    logic signed [31:0] rpm_q8;

    reading_t    readings_due[$];
    reading_t    arrived_want;
    plan_row_t   plan [PLAN_ROWS];
    cfg_t        settings [SETTINGS_USED];
    int          failures;
    int          cycles_run;
    int          requests_sent;
    int          edges_sent;
    int          updates_sent;
    int          stale_updates;
    int          clipped_speeds;
    int          burst_left;
    int          stall_left;
    stall_mode_t stall_mode;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(1, 40);
        end
        stall_left--;
        case (stall_mode)
            HOLD_OPEN:   result_stall <= 1'b0;
            HOLD_COIN:   result_stall <= 1'($urandom_range(0, 1));
            HOLD_LONG:   result_stall <= (stall_left < 12);
            default:     result_stall <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result: expected none, actual count %h", pulse_count);
                failures++;
            end
            else
            begin
                arrived_want = readings_due.pop_front();
                check_field("pulse_count", arrived_want.count, pulse_count);
                check_field("direction", {30'd0, arrived_want.dir}, {30'd0, direction});
                check_field("period_us", arrived_want.period, period_us);
                check_field("frequency_hz_q8", {4'd0, arrived_want.freq}, {4'd0, frequency_hz_q8});
                check_field("speed_rpm_q8", arrived_want.speed, speed_rpm_q8);
            end
        end
    end

    function automatic void apply_register(logic [1:0] index, logic [31:0] value);
        case (index)
            REG_PULSES:  meter_cfg.pulses = value[15:0];
            REG_GEAR:    meter_cfg.gear = value[15:0];
            REG_TIMEOUT: meter_cfg.timeout = value;
            default:     ;
        endcase
    endfunction

    function automatic logic [31:0] register_value(logic [1:0] index);
        case (index)
            REG_PULSES:  return {16'd0, meter_cfg.pulses};
            REG_GEAR:    return {16'd0, meter_cfg.gear};
            default:     return meter_cfg.timeout;
        endcase
    endfunction

    task automatic meter_step(input logic op, input logic [31:0] t, input logic b,
                              output reading_t r);
        logic [31:0] elapsed;
        logic [1:0]  dir_used;
        logic [63:0] divisor;
        logic [63:0] dividend;
        logic [63:0] magnitude;
        elapsed = t - last_edge_us;
        if (op == OP_EDGE)
        begin
            last_edge_us = t;
            period_total = period_total + elapsed;
            periods_seen = periods_seen + 4'd1;
            if (periods_seen >= AVG_TRIGGER)
            begin
                mean_period = period_total / AVG_DIVISOR;
                period_total = '0;
                periods_seen = '0;
            end
            if (b == 1'b0)
            begin
                edge_total = edge_total + 32'sd1;
                edge_dir = DIR_FWD;
            end
            else
            begin
                edge_total = edge_total - 32'sd1;
                edge_dir = DIR_REV;
            end
            dir_used = edge_dir;
            edges_sent++;
        end
        else
        begin
            dir_used = edge_dir;
            if (elapsed <= meter_cfg.timeout && mean_period != 0)
                freq_q8 = FREQ_NUM_Q8 / mean_period;
            else
            begin
                freq_q8 = '0;
                dir_used = DIR_NONE;
                stale_updates++;
            end
            divisor = 64'(meter_cfg.pulses) * 64'(meter_cfg.gear);
            dividend = 64'(freq_q8) * RPM_SCALE_Q8;
            if (dividend == 0)
                magnitude = '0;
            else if (divisor == 0)
                magnitude = 64'hFFFF_FFFF;
            else
                magnitude = dividend / divisor;
            case (dir_used)
                DIR_FWD:
                begin
                    if (magnitude > 64'h7FFF_FFFF)
                    begin
                        magnitude = 64'h7FFF_FFFF;
                        clipped_speeds++;
                    end
                    rpm_q8 = magnitude[31:0];
                end
                DIR_REV:
                begin
                    if (magnitude > 64'h8000_0000)
                    begin
                        magnitude = 64'h8000_0000;
                        clipped_speeds++;
                    end
                    rpm_q8 = -magnitude[31:0];
                end
                default: rpm_q8 = '0;
            endcase
            updates_sent++;
        end
        r.count = edge_total;
        r.dir = dir_used;
        r.period = mean_period;
        r.freq = freq_q8[27:0];
        r.speed = rpm_q8;
    endtask

    task automatic send_request(input logic op, input logic [31:0] t, input logic b,
                                input logic known, input reading_t want);
        reading_t predicted;
        int       idle;
        idle = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        repeat (idle)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        operation <= op;
        time_us <= t;
        channel_b_level <= b;
        do
            @(posedge clk);
        while (item_stall);
        meter_step(op, t, b, predicted);
        readings_due.push_back(known ? want : predicted);
        requests_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_register(index, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_register(input logic [1:0] index);
        logic [31:0] want;
        want = register_value(index);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {index, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("prdata at register %0d: expected %h, actual %h", index, want, prdata);
            failures++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_setting(input cfg_t setting);
        write_register(REG_PULSES, {16'($urandom), setting.pulses});
        write_register(REG_GEAR, {16'($urandom), setting.gear});
        write_register(REG_TIMEOUT, setting.timeout);
        read_register(REG_PULSES);
        read_register(REG_GEAR);
        read_register(REG_TIMEOUT);
    endtask

    initial
    begin
        logic        op;
        logic [31:0] t;
        logic        b;
        logic        forward_b;
        int unsigned pick;
        int unsigned pace;
        logic [31:0] age;

        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        operation = OP_EDGE;
        time_us = '0;
        channel_b_level = 1'b0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        failures = 0;
        cycles_run = 0;
        requests_sent = 0;
        edges_sent = 0;
        updates_sent = 0;
        stale_updates = 0;
        clipped_speeds = 0;
        burst_left = 0;
        stall_left = 0;
        stall_mode = HOLD_OPEN;
        meter_cfg = '{PULSES_RESET, GEAR_RESET, TIMEOUT_RESET};
        last_edge_us = '0;
        period_total = '0;
        periods_seen = '0;
        mean_period = '0;
        edge_dir = DIR_NONE;
        edge_total = '0;
        freq_q8 = '0;
        rpm_q8 = '0;

        // The first edge is measured from time zero; later rows cover the timeout boundary,
        // timestamp wrap, a zero averaged period and the shortest possible period.
        plan = '{
            '{OP_UPDATE, 32'd0,          1'b0, 1'b1, '{32'sd0, DIR_NONE, 32'd0, 28'd0, 32'sd0}},
            '{OP_EDGE,   32'd1000,       1'b0, 1'b1, '{32'sd1, DIR_FWD, 32'd0, 28'd0, 32'sd0}},
            '{OP_EDGE,   32'd2000,       1'b0, 1'b1, '{32'sd2, DIR_FWD, 32'd1000, 28'd0, 32'sd0}},
            '{OP_UPDATE, 32'd2500,       1'b1, 1'b0, NO_READING},
            '{OP_EDGE,   32'd3000,       1'b1, 1'b0, NO_READING},
            '{OP_EDGE,   32'd4000,       1'b1, 1'b0, NO_READING},
            '{OP_UPDATE, 32'd4100,       1'b0, 1'b0, NO_READING},
            '{OP_UPDATE, 32'd204000,     1'b0, 1'b0, NO_READING},
            '{OP_UPDATE, 32'd204001,     1'b0, 1'b1, '{32'sd0, DIR_NONE, 32'd1000, 28'd0, 32'sd0}},
            '{OP_EDGE,   32'hFFFF_FFF0,  1'b0, 1'b0, NO_READING},
            '{OP_EDGE,   32'h0000_0010,  1'b0, 1'b0, NO_READING},
            '{OP_UPDATE, 32'h0000_0020,  1'b0, 1'b0, NO_READING},
            '{OP_EDGE,   32'h0000_0030,  1'b0, 1'b0, NO_READING},
            '{OP_EDGE,   32'h0000_0030,  1'b0, 1'b0, NO_READING},
            '{OP_EDGE,   32'h0000_0030,  1'b0, 1'b0, NO_READING},
            '{OP_EDGE,   32'h0000_0030,  1'b0, 1'b0, NO_READING},
            '{OP_UPDATE, 32'h0000_0030,  1'b0, 1'b1, '{32'sd6, DIR_NONE, 32'd0, 28'd0, 32'sd0}},
            '{OP_EDGE,   32'h0000_0031,  1'b0, 1'b0, NO_READING},
            '{OP_EDGE,   32'h0000_0032,  1'b0, 1'b0, NO_READING},
            '{OP_UPDATE, 32'h0000_0032,  1'b0, 1'b0, NO_READING},
            '{OP_UPDATE, 32'hFFFF_FFFF,  1'b1, 1'b1, '{32'sd8, DIR_NONE, 32'd1, 28'd0, 32'sd0}},
            '{OP_EDGE,   32'hFFFF_FFFF,  1'b1, 1'b0, NO_READING},
            '{OP_EDGE,   32'hFFFF_FFFF,  1'b1, 1'b0, NO_READING},
            '{OP_UPDATE, 32'hFFFF_FFFF,  1'b1, 1'b0, NO_READING}
        };

        settings[0] = '{16'd1, 16'd1, 32'hFFFF_FFFF};
        settings[1] = '{16'hFFFF, 16'hFFFF, 32'd0};
        settings[2] = '{16'd0, GEAR_RESET, TIMEOUT_RESET};
        settings[3] = '{PULSES_RESET, 16'd0, 32'd5000};
        settings[4] = '{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), $urandom};
        settings[5] = '{PULSES_RESET, GEAR_RESET, TIMEOUT_RESET};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
            send_request(plan[i].op, plan[i].t, plan[i].b, plan[i].known, plan[i].want);
        drain_results();

        forward_b = 1'b0;
        pace = 1000;
        for (int s = 0; s < SETTINGS_USED; s++)
        begin
            if (s == 2)
                write_register(REG_UNUSED, $urandom);
            program_setting(settings[s]);
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       pace = $urandom_range(1, 16);
                        1:       pace = $urandom_range(100, 5000);
                        default: pace = $urandom_range(5000, 300000);
                    endcase
                end
                if (pick < 8)
                begin
                    op = 1'($urandom_range(0, 1));
                    t = $urandom;
                    b = 1'($urandom_range(0, 1));
                end
                else if (pick < 62)
                begin
                    if ($urandom_range(0, 19) == 0)
                        forward_b = ~forward_b;
                    op = OP_EDGE;
                    t = last_edge_us + pace + $urandom_range(0, pace / 8);
                    b = forward_b;
                end
                else
                begin
                    op = OP_UPDATE;
                    b = 1'($urandom_range(0, 1));
                    pick = $urandom_range(0, 9);
                    if (pick < 2)
                        age = '0;
                    else if (pick < 6)
                        age = $urandom_range(0, 2 * pace);
                    else if (pick < 7)
                        age = meter_cfg.timeout;
                    else if (pick < 8)
                        age = meter_cfg.timeout + 32'd1;
                    else
                        age = $urandom;
                    t = last_edge_us + age;
                end
                send_request(op, t, b, 1'b0, NO_READING);
            end
            drain_results();
        end

        $display("Run covered %0d requests (%0d edges, %0d updates) over %0d register settings.",
                 requests_sent, edges_sent, updates_sent, SETTINGS_USED + 1);
        $display("Updates timed out or without a period: %0d; speeds saturated: %0d.",
                 stale_updates, clipped_speeds);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
